@@ hw/rtl/tas_pkg.sv @@
// ----------------------------------------------------------------------------
// Tilt angle package
// Shared widths, CORDIC arctangent table, FSM codes and control types for the
// accelerometer tilt angle block.
// ----------------------------------------------------------------------------
`default_nettype none

package tas_pkg;

   localparam int IN_W           = 16;  // raw sample width
   localparam int ANG_W          = 15;  // output angle width
   localparam int ACC_FRAC       = 20;  // angle accumulator counts 2^-20 degree
   localparam int CORDIC_STEPS   = 24;
   localparam int STEP_W         = $clog2(CORDIC_STEPS);
   localparam int PRE_SHIFT      = 30;
   localparam int CORD_W         = 49;  // x/y datapath, holds 2^45 times gain
   localparam int Z_W            = 30;  // signed angle accumulator
   localparam int RAW_W          = 32;  // 180 +/- atan2 before rounding
   localparam int RND_W          = 34;  // rounding sum
   localparam int LANES          = 3;
   localparam int ANGLE_FRAC_DEF = 6;

   localparam logic signed [Z_W-1:0]   DEG180_Z   = Z_W'(180 * (1 << ACC_FRAC));
   localparam logic signed [RAW_W-1:0] DEG180_RAW = RAW_W'(180 * (1 << ACC_FRAC));
   localparam logic signed [RAW_W-1:0] DEG360_RAW = RAW_W'(360 * (1 << ACC_FRAC));

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CORDIC = 4'b0010,
      ST_ROUND  = 4'b0100,
      ST_SMOOTH = 4'b1000
   } tas_state_type;

   typedef struct packed {
      logic load;    // take lane angles into the merge stage
      logic round;   // convert to output units
      logic smooth;  // deadband filter and update kept angles
   } tas_merge_ctl_type;

   // atan(2^-i) in 2^-20 degree
   function automatic logic signed [Z_W-1:0] atan_lut(input logic [STEP_W-1:0] step);
      logic signed [Z_W-1:0] v;
      case (step)
         5'd0:    v = Z_W'(47185920);
         5'd1:    v = Z_W'(27855475);
         5'd2:    v = Z_W'(14718068);
         5'd3:    v = Z_W'(7471121);
         5'd4:    v = Z_W'(3750058);
         5'd5:    v = Z_W'(1876857);
         5'd6:    v = Z_W'(938658);
         5'd7:    v = Z_W'(469357);
         5'd8:    v = Z_W'(234682);
         5'd9:    v = Z_W'(117342);
         5'd10:   v = Z_W'(58671);
         5'd11:   v = Z_W'(29335);
         5'd12:   v = Z_W'(14668);
         5'd13:   v = Z_W'(7334);
         5'd14:   v = Z_W'(3667);
         5'd15:   v = Z_W'(1833);
         5'd16:   v = Z_W'(917);
         5'd17:   v = Z_W'(458);
         5'd18:   v = Z_W'(229);
         5'd19:   v = Z_W'(115);
         5'd20:   v = Z_W'(57);
         5'd21:   v = Z_W'(29);
         5'd22:   v = Z_W'(14);
         5'd23:   v = Z_W'(7);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tas_cordic_lane.sv @@
// ----------------------------------------------------------------------------
// Tilt angle CORDIC lane
// Vectoring-mode CORDIC, one micro-rotation per cycle, giving atan2(y, x)
// in 2^-20 degree over the range (-180, 180].
// ----------------------------------------------------------------------------
`default_nettype none

module tas_cordic_lane
   import tas_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [IN_W-1:0]   opnd_y,
   input  wire logic signed [IN_W-1:0]   opnd_x,
   output logic                          done,
   output logic signed [Z_W-1:0]         angle
);

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

   logic signed [CORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]    z_ff, z_in, angle_ff, angle_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic                     base_ff, base_in;
   logic                     run_ff, run_in, fin_ff, fin_in, done_ff, done_in;

   logic signed [CORD_W-1:0] x_ext, y_ext, dx, dy;
   logic                     y_pos, y_neg, last_step;

   always_comb begin
      x_ext     = CORD_W'(opnd_x) <<< PRE_SHIFT;
      y_ext     = CORD_W'(opnd_y) <<< PRE_SHIFT;
      dx        = x_ff >>> step_ff;
      dy        = y_ff >>> step_ff;
      y_neg     = y_ff[CORD_W-1];
      y_pos     = !y_neg && (y_ff != '0);
      last_step = (step_ff == LAST_STEP);

      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      step_in  = step_ff;
      base_in  = base_ff;
      angle_in = angle_ff;

      if (start) begin
         // fold the left half plane over, remember 180 degrees
         base_in = opnd_x[IN_W-1];
         x_in    = opnd_x[IN_W-1] ? -x_ext : x_ext;
         y_in    = opnd_x[IN_W-1] ? -y_ext : y_ext;
         z_in    = '0;
         step_in = '0;
      end else if (run_ff) begin
         if (y_pos) begin
            x_in = x_ff + dy;
            y_in = y_ff - dx;
            z_in = z_ff + atan_lut(step_ff);
         end else if (y_neg) begin
            x_in = x_ff - dy;
            y_in = y_ff + dx;
            z_in = z_ff - atan_lut(step_ff);
         end
         step_in = step_ff + 1'b1;
      end

      // add the fold back and wrap into (-180, 180]
      if (fin_ff) begin
         if (!base_ff) begin
            angle_in = z_ff;
         end else if (!z_ff[Z_W-1] && (z_ff != '0)) begin
            angle_in = z_ff - DEG180_Z;
         end else begin
            angle_in = z_ff + DEG180_Z;
         end
      end

      run_in  = start ? 1'b1 : (run_ff && !last_step);
      fin_in  = run_ff && last_step && !start;
      done_in = fin_ff;
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      step_ff  <= step_in;
      base_ff  <= base_in;
      angle_ff <= angle_in;
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   assign done  = done_ff;
   assign angle = angle_ff;

endmodule

`default_nettype wire

@@ hw/rtl/tas_merge.sv @@
// ----------------------------------------------------------------------------
// Tilt angle merge stage
// Turns the three lane arctangents into tilt angles in output units, then
// applies the deadband smoother against the kept angle of each axis.
// ----------------------------------------------------------------------------
`default_nettype none

module tas_merge
   import tas_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
)
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tas_merge_ctl_type             ctl,
   input  wire logic signed [LANES*Z_W-1:0]   lane_angle,
   input  wire logic [ANG_W-1:0]              threshold,
   output logic [LANES*ANG_W-1:0]             angle
);

   localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
   localparam logic [RND_W-1:0] HALF = RND_W'(1) << (SH - 1);

   logic signed [RAW_W-1:0] raw_ff  [LANES];
   logic signed [RAW_W-1:0] raw_in  [LANES];
   logic [ANG_W-1:0]        unit_ff [LANES];
   logic [ANG_W-1:0]        unit_in [LANES];
   logic [ANG_W-1:0]        last_ff [LANES];
   logic [ANG_W-1:0]        last_in [LANES];

   for (genvar i = 0; i < LANES; i++) begin : g_axis
      logic signed [RAW_W-1:0] z_ext, clamped;
      logic [RND_W-1:0]        rnd;
      logic [ANG_W-1:0]        diff;
      logic [ANG_W:0]          sum;

      always_comb begin
         z_ext = RAW_W'(signed'(lane_angle[i*Z_W +: Z_W]));
         // X axis tilts the other way round
         if (i == 0) begin
            raw_in[i] = ctl.load ? (DEG180_RAW - z_ext) : raw_ff[i];
         end else begin
            raw_in[i] = ctl.load ? (DEG180_RAW + z_ext) : raw_ff[i];
         end

         if (raw_ff[i][RAW_W-1]) begin
            clamped = '0;
         end else if (raw_ff[i] > DEG360_RAW) begin
            clamped = DEG360_RAW;
         end else begin
            clamped = raw_ff[i];
         end
         rnd        = RND_W'(unsigned'(clamped)) + HALF;
         unit_in[i] = ctl.round ? rnd[SH +: ANG_W] : unit_ff[i];

         diff = (unit_ff[i] > last_ff[i]) ? (unit_ff[i] - last_ff[i])
                                          : (last_ff[i] - unit_ff[i]);
         sum  = {1'b0, unit_ff[i]} + {1'b0, last_ff[i]};
         if (!ctl.smooth) begin
            last_in[i] = last_ff[i];
         end else if (diff < threshold) begin
            last_in[i] = sum[ANG_W:1];
         end else begin
            last_in[i] = unit_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         raw_ff[i]  <= raw_in[i];
         unit_ff[i] <= unit_in[i];
         if (reset) begin
            last_ff[i] <= '0;
         end else begin
            last_ff[i] <= last_in[i];
         end
      end

      // the kept angle doubles as the output word
      assign angle[i*ANG_W +: ANG_W] = last_ff[i];
   end

endmodule

`default_nettype wire

@@ hw/rtl/accel_tilt_angles_deadband_smooth_top.sv @@
// Flow: one word at a time; three CORDIC lanes run 24 rotations
//   side by side, one per cycle, then wrap, load, rounding and smoothing follow
//   in turn, smoothing waiting for the previous word to leave. req_tready stays
//   low while a word is in flight.
// Reset: synchronous, active high; clears the kept angles, the threshold
//   and all control state.
// ----------------------------------------------------------------------------
// Accelerometer tilt angles with deadband smoothing
// Three atan2 tilt angles per sample in 2^-ANGLE_FRAC_BITS degree, each
// smoothed against its last output below a programmable threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_tilt_angles_deadband_smooth_top
   import tas_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   // req_tdata: accel_x [15:0], accel_y [31:16], accel_z [47:32]
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [47:0]   req_tdata,
   // rsp_tdata: angle_x [14:0], angle_y [29:15], angle_z [44:30], zero [47:45]
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [47:0]        rsp_tdata,
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [2:0]    csr_paddr,
   input  wire logic [31:0]   csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   tas_state_type               state_ff, state_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ANG_W-1:0]            thresh_ff, thresh_in;
   logic                        req_accept, out_free, all_done;
   logic [LANES-1:0]            lane_done;
   logic signed [LANES*Z_W-1:0] lane_angle;
   logic [LANES*ANG_W-1:0]      angle;
   tas_merge_ctl_type           merge_ctl;
   logic signed [IN_W-1:0]      acc_x, acc_y, acc_z;
   logic                        csr_sel_thresh;

   assign acc_x = req_tdata[15:0];
   assign acc_y = req_tdata[31:16];
   assign acc_z = req_tdata[47:32];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign all_done   = &lane_done;

   // lane 0: atan2(y, x), lane 1: atan2(z, x), lane 2: atan2(x, z)
   tas_cordic_lane u_lane_x (
      .clock  (clock),
      .reset  (reset),
      .start  (req_accept),
      .opnd_y (acc_y),
      .opnd_x (acc_x),
      .done   (lane_done[0]),
      .angle  (lane_angle[0*Z_W +: Z_W])
   );

   tas_cordic_lane u_lane_y (
      .clock  (clock),
      .reset  (reset),
      .start  (req_accept),
      .opnd_y (acc_z),
      .opnd_x (acc_x),
      .done   (lane_done[1]),
      .angle  (lane_angle[1*Z_W +: Z_W])
   );

   tas_cordic_lane u_lane_z (
      .clock  (clock),
      .reset  (reset),
      .start  (req_accept),
      .opnd_y (acc_x),
      .opnd_x (acc_z),
      .done   (lane_done[2]),
      .angle  (lane_angle[2*Z_W +: Z_W])
   );

   tas_merge #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .ctl        (merge_ctl),
      .lane_angle (lane_angle),
      .threshold  (thresh_ff),
      .angle      (angle)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      merge_ctl    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_CORDIC;
            end
         end
         ST_CORDIC: begin
            if (all_done) begin
               merge_ctl.load = 1'b1;
               state_in       = ST_ROUND;
            end
         end
         ST_ROUND: begin
            merge_ctl.round = 1'b1;
            state_in        = ST_SMOOTH;
         end
         ST_SMOOTH: begin
            // hold until the previous word has left
            if (out_free) begin
               merge_ctl.smooth = 1'b1;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign csr_sel_thresh = (csr_paddr[2] == 1'b0);
   assign thresh_in = (csr_psel && csr_penable && csr_pwrite && csr_sel_thresh)
                      ? csr_pwdata[ANG_W-1:0] : thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         thresh_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         thresh_ff    <= thresh_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, angle};
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_sel_thresh ? {{(32-ANG_W){1'b0}}, thresh_ff} : 32'd0;

   a_ready_drops: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("req_tready still high after an accepted word");

   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      lane_done[0] |-> (lane_done[1] && lane_done[2]))
      else $error("CORDIC lanes out of step");

   a_done_in_cordic: assert property (@(posedge clock) disable iff (reset)
      lane_done[0] |-> (state_ff == ST_CORDIC))
      else $error("lane finished outside the CORDIC state");

   a_smooth_slot_free: assert property (@(posedge clock) disable iff (reset)
      merge_ctl.smooth |-> out_free)
      else $error("kept angles updated while a word is still pending");

endmodule

`default_nettype wire

@@ sim/accel_tilt_angles_deadband_smooth_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt angle block testbench
// Streams accelerometer triples into the block under several idle and stall
// patterns and smoothing thresholds. An in-bench integer CORDIC predicts the
// three smoothed angles of every accepted word, and each result word is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module accel_tilt_angles_deadband_smooth_top_tb;
   import tas_pkg::*;

   localparam logic [2:0] REG_SMOOTH_THRESHOLD = 3'd0;
   localparam int         UNIT_SHIFT           = ACC_FRAC - ANGLE_FRAC_DEF;
   localparam longint     HALF_TURN            = longint'(180) << ACC_FRAC;
   localparam longint     FULL_TURN            = longint'(360) << ACC_FRAC;
   localparam int         THRESHOLD_MAX        = 23040;

   // atan(2^-i) in 2^-20 degree
   localparam longint ATAN_STEP [CORDIC_STEPS] = '{
      47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
      234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
      917, 458, 229, 115, 57, 29, 14, 7
   };

   typedef struct packed {
      logic signed [15:0] z;
      logic signed [15:0] y;
      logic signed [15:0] x;
   } accel_sample_type;

   typedef struct packed {
      logic [2:0]  pad;
      logic [14:0] az;
      logic [14:0] ay;
      logic [14:0] ax;
   } tilt_angles_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic [47:0] req_tdata   = '0;   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
   logic        rsp_tready  = 1'b0;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   wire logic        req_tready;
   wire logic        rsp_tvalid;
   wire logic [47:0] rsp_tdata;    // angle_x [14:0], angle_y [29:15], angle_z [44:30], zero [47:45]
   wire logic [31:0] csr_prdata;
   wire logic        csr_pready;

   int unsigned   idle_pct  = 0;
   int unsigned   stall_pct = 0;
   bit            sink_hold = 1'b0;
   int unsigned   error_count = 0;

   // predictor state
   logic [31:0]      smooth_thr = '0;
   logic [14:0]      kept_angle [3] = '{default: '0};
   tilt_angles_type  expected_angles [$];

   accel_tilt_angles_deadband_smooth_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   // atan2(y, x) in 2^-20 degree, range (-180, 180]
   function automatic longint cordic_atan2(longint yv, longint xv);
      longint cx, cy, acc, base, dx, dy;
      if (xv == 0 && yv == 0) return 0;
      cx   = xv;
      cy   = yv;
      acc  = 0;
      base = 0;
      if (cx < 0) begin
         cx   = -cx;
         cy   = -cy;
         base = HALF_TURN;
      end
      cx = cx * (longint'(1) << PRE_SHIFT);
      cy = cy * (longint'(1) << PRE_SHIFT);
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = cx >>> i;
         dy = cy >>> i;
         if (cy > 0) begin
            cx += dy;
            cy -= dx;
            acc += ATAN_STEP[i];
         end else if (cy < 0) begin
            cx -= dy;
            cy += dx;
            acc -= ATAN_STEP[i];
         end
      end
      acc += base;
      if (acc > HALF_TURN) acc -= FULL_TURN;
      return acc;
   endfunction

   function automatic logic [14:0] angle_to_units(longint v);
      longint r;
      r = v;
      if (r < 0) r = 0;
      if (r > FULL_TURN) r = FULL_TURN;
      r = (r + (longint'(1) << (UNIT_SHIFT - 1))) >>> UNIT_SHIFT;
      return r[14:0];
   endfunction

   function automatic logic [14:0] deadband_filter(int axis, logic [14:0] a);
      logic [31:0] prev, diff, res;
      prev = 32'(kept_angle[axis]);
      diff = (32'(a) > prev) ? 32'(a) - prev : prev - 32'(a);
      res  = (diff < smooth_thr) ? (32'(a) + prev) >> 1 : 32'(a);
      kept_angle[axis] = res[14:0];
      return res[14:0];
   endfunction

   function automatic tilt_angles_type predict_angles(accel_sample_type s);
      tilt_angles_type r;
      longint x, y, z;
      x = s.x;
      y = s.y;
      z = s.z;
      r.pad = '0;
      r.ax  = deadband_filter(0, angle_to_units(HALF_TURN - cordic_atan2(y, x)));
      r.ay  = deadband_filter(1, angle_to_units(HALF_TURN + cordic_atan2(z, x)));
      r.az  = deadband_filter(2, angle_to_units(HALF_TURN + cordic_atan2(x, z)));
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void check_field(string name, logic [14:0] want, logic [14:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Handshake signals only move at rising edges, so the falling edge sees
   // exactly what the next rising edge will accept.
   always @(negedge clock) begin : scoreboard
      tilt_angles_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_angles.size() == 0) begin
            $error("result word %h with no prediction pending", rsp_tdata);
            error_count++;
         end else begin
            want = expected_angles.pop_front();
            check_field("angle_x", want.ax, got.ax);
            check_field("angle_y", want.ay, got.ay);
            check_field("angle_z", want.az, got.az);
            check_field("zero", 15'(want.pad), 15'(got.pad));
         end
      end
      if (!reset && req_tvalid && req_tready)
         expected_angles.push_back(predict_angles(req_tdata));
   end

   always @(posedge clock) begin
      rsp_tready <= !sink_hold && ($urandom_range(99) >= stall_pct);
   end

   // ---------------------------------------------------------------- drivers

   task automatic send_sample(accel_sample_type s);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      wait (expected_angles.size() == 0);
      repeat (32) @(posedge clock);
   endtask

   task automatic set_threshold(int unsigned value);
      wait_idle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= REG_SMOOTH_THRESHOLD;
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (!csr_pready);
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      smooth_thr  = 32'(value[14:0]);
   endtask

   task automatic hold_sink_for(int unsigned cycles);
      @(negedge clock);
      sink_hold = 1'b1;
      repeat (cycles) @(posedge clock);
      @(negedge clock);
      sink_hold = 1'b0;
   endtask

   function automatic accel_sample_type make_sample(int x, int y, int z);
      accel_sample_type s;
      s.x = 16'(x);
      s.y = 16'(y);
      s.z = 16'(z);
      return s;
   endfunction

   function automatic int small_val();
      return int'($urandom_range(8)) - 4;
   endfunction

   function automatic accel_sample_type random_sample();
      int unsigned pick;
      int big;
      pick = $urandom_range(99);
      big  = $urandom_range(1) ? -int'($urandom_range(32768, 1)) : int'($urandom_range(32767, 1));
      if (pick < 55)
         return make_sample(int'($urandom), int'($urandom), int'($urandom));
      else if (pick < 75)
         return make_sample(small_val(), small_val(), small_val());
      // one axis dominant, the others zero or tiny
      case ($urandom_range(2))
         0:       return make_sample(big, $urandom_range(1) ? 0 : small_val(), 0);
         1:       return make_sample(0, big, $urandom_range(1) ? 0 : small_val());
         default: return make_sample($urandom_range(1) ? 0 : small_val(), 0, big);
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_corner_samples();
      send_sample(make_sample(0, 0, 0));
      send_sample(make_sample(-1, 0, 0));
      send_sample(make_sample(0, 0, -5));
      send_sample(make_sample(-32768, 0, 0));
      send_sample(make_sample(0, -32768, -32768));
      send_sample(make_sample(32767, 32767, 32767));
      send_sample(make_sample(-32768, -32768, -32768));
      send_sample(make_sample(-32768, 32767, -32768));
      send_sample(make_sample(32767, -32768, 0));
      send_sample(make_sample(-32768, -1, -1));
      send_sample(make_sample(-32768, 1, 1));
      send_sample(make_sample(1, -32768, 32767));
      send_sample(make_sample(0, 1, 0));
      send_sample(make_sample(0, -1, 0));
      wait_idle();
   endtask

   task automatic test_threshold_extremes();
      set_threshold(THRESHOLD_MAX);
      send_sample(make_sample(100, 200, 300));
      send_sample(make_sample(-32768, 0, 32767));
      send_sample(make_sample(-32768, 0, 32767));
      send_sample(make_sample(5, -7, 0));
      set_threshold(1);
      send_sample(make_sample(1000, 1000, 1000));
      send_sample(make_sample(1000, 1000, 1000));
      send_sample(make_sample(1000, 1001, 999));
      wait_idle();
   endtask

   task automatic test_backpressure();
      set_threshold(64);
      idle_pct  = 0;
      stall_pct = 0;
      fork
         hold_sink_for(400);
      join_none
      repeat (10) send_sample(random_sample());
      wait_idle();
   endtask

   // mostly slow drifts around a tilt so the smoother engages, plus scattered samples
   task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned thr,
                            int unsigned count);
      int unsigned sent;
      int unsigned run_len;
      int bx, by, bz;
      set_threshold(thr);
      idle_pct  = idle;
      stall_pct = stall;
      sent      = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 60) begin
            run_len = $urandom_range(16, 4);
            bx = int'($urandom_range(32000)) - 16000;
            by = int'($urandom_range(32000)) - 16000;
            bz = int'($urandom_range(32000)) - 16000;
            repeat (run_len) begin
               bx += int'($urandom_range(64)) - 32;
               by += int'($urandom_range(64)) - 32;
               bz += int'($urandom_range(64)) - 32;
               send_sample(make_sample(bx, by, bz));
            end
            sent += run_len;
         end else begin
            send_sample(random_sample());
            sent++;
         end
      end
   endtask

   task automatic test_random_traffic();
      run_phase(0, 0, 0, 330);
      run_phase(60, 0, THRESHOLD_MAX, 330);
      run_phase(0, 60, $urandom_range(THRESHOLD_MAX), 330);
      run_phase(38, 38, $urandom_range(256, 1), 330);
      idle_pct  = 0;
      stall_pct = 0;
      wait_idle();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_samples();
      test_threshold_extremes();
      test_backpressure();
      test_random_traffic();
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/tas_pkg.sv
hw/rtl/tas_cordic_lane.sv
hw/rtl/tas_merge.sv
hw/rtl/accel_tilt_angles_deadband_smooth_top.sv
sim/accel_tilt_angles_deadband_smooth_top_tb.sv
